[rtl/pli_pkg.sv]
// shared types and constants for the piecewise linear interpolator
// no dependencies; pli_muldiv, piecewise_linear_interp and pli_checker import this package
`default_nettype none

package pli_pkg;

    // breakpoint table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // coordinate format is signed q16.16; the ratio form needs no rescale
    localparam int COORD_W  = 32;
    localparam int MD_STEPS = COORD_W;
    localparam int STEP_W   = $clog2(MD_STEPS);

    localparam logic signed [COORD_W-1:0] VALUE_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] VALUE_MIN = 32'sh80000000;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] value;
        logic                      table_empty;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SCAN,
        S_PREP,
        S_MULDIV,
        S_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] mag;
        logic [COORD_W-1:0] span;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] quot;
    } md_rsp_t;

endpackage

`default_nettype wire

[rtl/pli_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module pli_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/pli_muldiv.sv]
// serial unsigned multiply then divide: (dx * mag) / span, one adder shared
// depends on pli_pkg
`default_nettype none

module pli_muldiv (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pli_pkg::md_req_t  md_req,
    output pli_pkg::md_rsp_t       md_rsp
);

    import pli_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MD_STEPS - 1);

    md_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;
    logic [COORD_W:0]   hi_reg, hi_next;
    logic [COORD_W-1:0] lo_reg, lo_next;
    logic [COORD_W-1:0] dx_reg, dx_next;
    logic [COORD_W-1:0] span_reg, span_next;

    logic [COORD_W+1:0] add_a, add_b, add_sum;
    logic               add_cin;
    logic [COORD_W:0]   rem_shift;

    // shared adder: accumulate in multiply, trial subtract in divide
    always_comb
    begin
        rem_shift = {hi_reg[COORD_W-1:0], lo_reg[COORD_W-1]};
        case (state_reg)
            MD_MUL:
            begin
                add_a   = {1'b0, hi_reg};
                add_b   = lo_reg[0] ? {2'b00, dx_reg} : '0;
                add_cin = 1'b0;
            end
            MD_DIV:
            begin
                add_a   = {1'b0, rem_shift};
                add_b   = ~{2'b00, span_reg};
                add_cin = 1'b1;
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = add_a + add_b + {{(COORD_W+1){1'b0}}, add_cin};
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        dx_next    = dx_reg;
        span_next  = span_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (md_req.start)
                begin
                    hi_next    = '0;
                    lo_next    = md_req.mag;
                    dx_next    = md_req.dx;
                    span_next  = md_req.span;
                    step_next  = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                // shift right through hi:lo, product ends split across both
                hi_next   = {1'b0, add_sum[COORD_W:1]};
                lo_next   = {add_sum[0], lo_reg[COORD_W-1:1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                // high half is below span, so 32 restoring steps suffice
                hi_next   = add_sum[COORD_W+1] ? rem_shift : add_sum[COORD_W:0];
                lo_next   = {lo_reg[COORD_W-2:0], ~add_sum[COORD_W+1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        dx_reg   <= dx_next;
        span_reg <= span_next;
    end

    assign md_rsp.done = done_reg;
    assign md_rsp.quot = lo_reg;

endmodule

`default_nettype wire

[rtl/piecewise_linear_interp.sv]
// piecewise linear interpolator: breakpoint table, search sequencer, result register
// depends on pli_pkg, pli_ram, pli_muldiv
//
//   channel   signals                        payload   direction
//   request   req_valid / req_stall          req_t     in  (clear, append, evaluate)
//   result    res_valid / res_stall          res_t     out (one per evaluate)
//
// clear, append and reserved codes complete in S_IDLE; req_stall stays low after them
// evaluate goes straight to S_DONE with no or one point or right of range, through S_FIRST
//   left of range, else it scans the table, one entry per scan cycle, to S_PREP, which
//   finishes a zero-width segment or starts the 32 + 32 step shared multiply/divide
// reset clears the point count and the sequencer; table contents are not cleared
// a finished result waits in a holding state while the output register is stalled

`default_nettype none

module piecewise_linear_interp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire pli_pkg::req_t  req_data,
    output logic                res_valid,
    input  wire logic           res_stall,
    output pli_pkg::res_t       res_data
);

    import pli_pkg::*;

    // sequencer and table bookkeeping
    seq_state_t                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          last_idx;

    // last appended point, kept for order check and the right-hand clamp
    logic signed [COORD_W-1:0] last_x_reg, last_x_next;
    logic signed [COORD_W-1:0] last_y_reg, last_y_next;

    // query and the current segment
    logic signed [COORD_W-1:0] qx_reg, qx_next;
    logic signed [COORD_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [COORD_W-1:0] x2_reg, x2_next, y2_reg, y2_next;
    logic                      neg_reg, neg_next;

    // result holding and output register
    res_t                      result_reg, result_next;
    logic                      res_valid_reg, res_valid_next;
    res_t                      res_data_reg, res_data_next;
    logic                      res_load;

    // table ram
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr, ram_raddr;
    logic [2*COORD_W-1:0]      ram_wdata, ram_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;

    // segment arithmetic
    logic                      req_accept;
    logic                      append_ok;
    logic [COORD_W:0]          dx_full, span_full, dy_full, mag_full;
    logic [COORD_W+1:0]        y1_ext, q_ext, sum_ext;
    logic signed [COORD_W-1:0] interp_val;
    md_req_t                   md_req;
    md_rsp_t                   md_rsp;

    pli_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    pli_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .md_req (md_req),
        .md_rsp (md_rsp)
    );

    assign rd_x      = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_y      = ram_rdata[COORD_W-1:0];
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign req_stall = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;

    // appends must keep x non-decreasing and fit in the table
    assign append_ok = (count_reg < CNT_W'(TABLE_DEPTH)) &&
                       ((count_reg == '0) || (req_data.x_coord >= last_x_reg));

    // dx, span and |dy| for the segment; dx and span never exceed 32 bits
    always_comb
    begin
        dx_full   = {qx_reg[COORD_W-1], qx_reg} - {x1_reg[COORD_W-1], x1_reg};
        span_full = {x2_reg[COORD_W-1], x2_reg} - {x1_reg[COORD_W-1], x1_reg};
        dy_full   = {y2_reg[COORD_W-1], y2_reg} - {y1_reg[COORD_W-1], y1_reg};
        mag_full  = dy_full[COORD_W] ? (~dy_full + (COORD_W+1)'(1)) : dy_full;
    end

    assign md_req.start = (state_reg == S_PREP) && (x1_reg != x2_reg);
    assign md_req.dx    = dx_full[COORD_W-1:0];
    assign md_req.span  = span_full[COORD_W-1:0];
    assign md_req.mag   = mag_full[COORD_W-1:0];

    // y1 plus or minus the quotient, clamped to the signed 32-bit range
    always_comb
    begin
        y1_ext  = {{2{y1_reg[COORD_W-1]}}, y1_reg};
        q_ext   = {2'b00, md_rsp.quot};
        sum_ext = neg_reg ? (y1_ext - q_ext) : (y1_ext + q_ext);
        if ((sum_ext[COORD_W+1:COORD_W-1] == 3'b000) ||
            (sum_ext[COORD_W+1:COORD_W-1] == 3'b111))
        begin
            interp_val = sum_ext[COORD_W-1:0];
        end
        else if (sum_ext[COORD_W+1])
        begin
            interp_val = VALUE_MIN;
        end
        else
        begin
            interp_val = VALUE_MAX;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        qx_next     = qx_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        x2_next     = x2_reg;
        y2_next     = y2_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        res_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[IDX_W-1:0];
        ram_wdata   = {req_data.x_coord, req_data.y_coord};
        ram_raddr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                // entry 0 is always fetched so it is ready for the first check
                ram_raddr = '0;
                if (req_accept)
                begin
                    case (req_data.operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (append_ok)
                            begin
                                ram_we      = 1'b1;
                                last_x_next = req_data.x_coord;
                                last_y_next = req_data.y_coord;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        OP_EVAL:
                        begin
                            qx_next = req_data.x_coord;
                            if (count_reg == '0)
                            begin
                                result_next.value       = '0;
                                result_next.table_empty = 1'b1;
                                state_next              = S_DONE;
                            end
                            else if ((count_reg == CNT_W'(1)) ||
                                     (last_x_reg < req_data.x_coord))
                            begin
                                // single point or right of range
                                result_next.value       = last_y_reg;
                                result_next.table_empty = 1'b0;
                                state_next              = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FIRST;
                            end
                        end
                        default:
                        begin
                            // reserved code: no state change, no result
                        end
                    endcase
                end
            end
            S_FIRST:
            begin
                ram_raddr = IDX_W'(1);
                if (rd_x > qx_reg)
                begin
                    // left of range
                    result_next.value       = rd_y;
                    result_next.table_empty = 1'b0;
                    state_next              = S_DONE;
                end
                else
                begin
                    x1_next    = rd_x;
                    y1_next    = rd_y;
                    idx_next   = IDX_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ram_raddr = idx_reg + IDX_W'(1);
                if ((idx_reg < last_idx) && (rd_x < qx_reg))
                begin
                    x1_next  = rd_x;
                    y1_next  = rd_y;
                    idx_next = idx_reg + IDX_W'(1);
                end
                else
                begin
                    x2_next    = rd_x;
                    y2_next    = rd_y;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (x1_reg == x2_reg)
                begin
                    // zero-width segment
                    result_next.value       = y1_reg;
                    result_next.table_empty = 1'b0;
                    state_next              = S_DONE;
                end
                else
                begin
                    neg_next   = dy_full[COORD_W];
                    state_next = S_MULDIV;
                end
            end
            S_MULDIV:
            begin
                if (md_rsp.done)
                begin
                    result_next.value       = interp_val;
                    result_next.table_empty = 1'b0;
                    state_next              = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free this cycle
                if (!res_valid_reg || !res_stall)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        res_data_next = res_data_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_data_next  = result_reg;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_x_reg   <= last_x_next;
        last_y_reg   <= last_y_next;
        qx_reg       <= qx_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        x2_reg       <= x2_next;
        y2_reg       <= y2_next;
        neg_reg      <= neg_next;
        result_reg   <= result_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

[rtl/pli_checker.sv]
// port-level checks for the piecewise linear interpolator, bound to the top level
// depends on pli_pkg and piecewise_linear_interp
`default_nettype none

module pli_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire pli_pkg::req_t  req_data,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire pli_pkg::res_t  res_data
);

    import pli_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

    // an accepted evaluate always keeps the block busy the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_data.operation == OP_EVAL) |=> req_stall)
    else $error("evaluate request did not occupy the block");

    // a table update leaves req_stall low the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall &&
        ((req_data.operation == OP_CLEAR) || (req_data.operation == OP_APPEND))
        |=> !req_stall)
    else $error("table update held the request channel");

    // an empty table result carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.table_empty |-> (res_data.value == '0))
    else $error("empty table result with nonzero value");

    // a new result only appears while an evaluate is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_stall))
    else $error("result appeared without an evaluate in progress");

endmodule

bind piecewise_linear_interp pli_checker u_pli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

`default_nettype wire
